[rtl/gbad_pkg.sv]
// shared types and constants of the grid block average decimator
// no dependencies; used by every module of the block

package gbad_pkg;

    // default sizing of the top level
    localparam int DEF_MAX_SRC_WIDTH  = 4096;
    localparam int DEF_MAX_SRC_HEIGHT = 4096;
    localparam int DEF_MAX_DST_WIDTH  = 1024;
    localparam int DEF_SAMPLE_BITS    = 16;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int SRC_DIM_W   = 13;
    localparam int DST_X_W     = 11;
    localparam int DST_Y_W     = 13;
    localparam int OUT_X_W     = 10;
    localparam int OUT_Y_W     = 12;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = 2 * SRC_DIM_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // register reset values
    localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = SRC_DIM_W'(4096);
    localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = SRC_DIM_W'(4096);
    localparam logic [DST_X_W-1:0]   RST_DST_WIDTH  = DST_X_W'(1024);
    localparam logic [DST_Y_W-1:0]   RST_DST_HEIGHT = DST_Y_W'(1024);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // clamped grid geometry
    typedef struct packed {
        logic [SRC_DIM_W-1:0] sw;
        logic [SRC_DIM_W-1:0] sh;
        logic [DST_X_W-1:0]   dw;
        logic [DST_Y_W-1:0]   dh;
    } t_geom;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CFG_X,
        ST_CFG_Y,
        ST_ACC,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[rtl/grid_block_average_decimator.sv]
// Grid block average decimator: shrinks a raster-order source grid to
// dst_width x dst_height bins, emitting each bin's truncated mean.
// Source samples enter on the s-side stream (tdata[15:0] = sample). A result
// word leaves on the m-side stream: tdata[15:0] average, [25:16] bin column,
// [37:26] bin row; tlast marks the bin that closes the frame.
// Sizes are set through the cfg write channel (index 0..3: src_width,
// src_height, dst_width, dst_height); the bin sizes are then worked out by a
// shared serial divider, with s_tready held low meanwhile.
// A sample that closes no bin goes through a ram read, then add and write
// back. A sample that closes a bin then also waits for the bit-serial
// divide of the bin sum by its sample count, with s_tready low meanwhile.
// One row of bin sums lives in a ram of MAX_DST_WIDTH words.
// After reset the ram is swept to zero, and the bin sizes of the reset
// geometry are computed before the first sample is taken.
// Results sit in an output register; while the receiver stalls, the next
// samples are still accepted until another bin result is ready to leave.
// depends on gbad_pkg, gbad_cfg, gbad_div and gbad_ram

module grid_block_average_decimator #(
    parameter int MAX_SRC_WIDTH  = gbad_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = gbad_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_WIDTH  = gbad_pkg::DEF_MAX_DST_WIDTH,
    parameter int SAMPLE_BITS    = gbad_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [gbad_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [15:0] sample
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [gbad_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // average, out_x, out_y
    output logic                               o_m_tlast,   // frame_done
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gbad_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [gbad_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gbad_pkg::*;

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int BW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam logic [SUM_W-1:0] SAMPLE_MAX = SUM_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // geometry and control
    t_geom                w_geom;
    logic                 w_cfg_wr;
    t_state               r_state;
    t_state               n_state;
    logic                 r_dirty;
    logic [BW-1:0]        r_clr_addr;

    // position counters
    logic [XW-1:0]        r_src_col;
    logic [XW-1:0]        r_col_in_bin;
    logic [YW-1:0]        r_src_row;
    logic [YW-1:0]        r_row_in_band;
    logic [BW-1:0]        r_bin_col;
    logic [YW-1:0]        r_band_row;

    // bin sizes and remainders
    logic [SRC_DIM_W-1:0] r_bx;
    logic [DST_X_W-1:0]   r_rx;
    logic [SRC_DIM_W-1:0] r_by;
    logic [DST_Y_W-1:0]   r_ry;

    // item in flight
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [BW-1:0]        r_idx;
    logic                 r_emit;
    logic                 r_last_bin_x;
    logic                 r_last_band;
    logic [OUT_X_W-1:0]   r_out_x;
    logic [OUT_Y_W-1:0]   r_out_y;
    logic                 r_frame_done;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_count;

    // output register
    logic                 r_m_tvalid;
    logic [SAMPLE_W-1:0]  r_m_avg;
    logic [OUT_X_W-1:0]   r_m_x;
    logic [OUT_Y_W-1:0]   r_m_y;
    logic                 r_m_last;

    // position flags
    logic                 w_last_bin_x;
    logic                 w_last_band;
    logic                 w_row_end;
    logic                 w_frame_row;
    logic                 w_bin_x_end;
    logic                 w_band_end;
    logic                 w_emit;

    // sequencer outputs
    logic                 w_accept;
    logic                 w_s_tready;
    logic                 w_ram_we;
    logic [BW-1:0]        w_ram_waddr;
    logic [SUM_W-1:0]     w_ram_wdata;
    logic                 w_div_start;
    logic                 w_cfg_start;
    logic                 w_cap_x;
    logic                 w_cap_y;
    logic                 w_out_load;
    logic [SUM_W-1:0]     w_div_dividend;
    logic [CNT_W-1:0]     w_div_divisor;

    // datapath
    t_div_stat            w_div_stat;
    logic [SUM_W-1:0]     w_div_quo;
    logic [CNT_W-1:0]     w_div_rem;
    logic [SUM_W-1:0]     w_ram_rdata;
    logic [SUM_W-1:0]     w_sum;
    logic [SRC_DIM_W-1:0] w_cx;
    logic [SRC_DIM_W-1:0] w_cy;
    logic [CNT_W-1:0]     w_prod;
    logic [SUM_W-1:0]     w_avg;

    gbad_cfg #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_WIDTH  (MAX_DST_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom),
        .o_wr        (w_cfg_wr)
    );

    gbad_div #(
        .NW (SUM_W),
        .DW (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_stat     (w_div_stat),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    gbad_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_bin_col),
        .o_rdata (w_ram_rdata)
    );

    // end-of-bin, band, row and frame detection
    assign w_last_bin_x = (32'(r_bin_col) + 32'd1) >= 32'(w_geom.dw);
    assign w_last_band  = (32'(r_band_row) + 32'd1) >= 32'(w_geom.dh);
    assign w_row_end    = (32'(r_src_col) + 32'd1) >= 32'(w_geom.sw);
    assign w_frame_row  = (32'(r_src_row) + 32'd1) >= 32'(w_geom.sh);
    assign w_bin_x_end  = w_last_bin_x ? w_row_end
                                       : ((32'(r_col_in_bin) + 32'd1) >= 32'(r_bx));
    assign w_band_end   = w_last_band ? w_frame_row
                                      : ((32'(r_row_in_band) + 32'd1) >= 32'(r_by));
    assign w_emit       = w_bin_x_end & w_band_end;

    assign w_accept   = i_s_tvalid & w_s_tready;
    assign o_s_tready = w_s_tready;

    // accumulate, bin count and saturated mean
    assign w_sum  = w_ram_rdata + SUM_W'(r_sample);
    assign w_cx   = r_last_bin_x ? SRC_DIM_W'(r_bx + SRC_DIM_W'(r_rx)) : r_bx;
    assign w_cy   = r_last_band ? SRC_DIM_W'(r_by + SRC_DIM_W'(r_ry)) : r_by;
    assign w_prod = w_cx * w_cy;
    assign w_avg  = (w_div_quo > SAMPLE_MAX) ? SAMPLE_MAX : w_div_quo;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BW'(MAX_DST_WIDTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                priority if (r_dirty) begin
                    n_state = ST_CFG_X;
                end else if (i_s_tvalid) begin
                    n_state = ST_ACC;
                end
            end
            ST_CFG_X: begin
                if (w_div_stat.done) begin
                    n_state = ST_CFG_Y;
                end
            end
            ST_CFG_Y: begin
                if (w_div_stat.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACC: begin
                n_state = r_emit ? ST_DSTART : ST_IDLE;
            end
            ST_DSTART: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_s_tready     = 1'b0;
        w_ram_we       = 1'b0;
        w_ram_waddr    = r_idx;
        w_ram_wdata    = '0;
        w_div_start    = 1'b0;
        w_cfg_start    = 1'b0;
        w_cap_x        = 1'b0;
        w_cap_y        = 1'b0;
        w_out_load     = 1'b0;
        w_div_dividend = r_sum;
        w_div_divisor  = r_count;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
            end
            ST_IDLE: begin
                w_s_tready     = !r_dirty;
                w_div_start    = r_dirty;
                w_cfg_start    = r_dirty;
                w_div_dividend = SUM_W'(w_geom.sw);
                w_div_divisor  = CNT_W'(w_geom.dw);
            end
            ST_CFG_X: begin
                w_cap_x        = w_div_stat.done;
                w_div_start    = w_div_stat.done;
                w_div_dividend = SUM_W'(w_geom.sh);
                w_div_divisor  = CNT_W'(w_geom.dh);
            end
            ST_CFG_Y: begin
                w_cap_y = w_div_stat.done;
            end
            ST_ACC: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = r_emit ? '0 : w_sum;
            end
            ST_DSTART: begin
                w_div_start = 1'b1;
            end
            ST_DIV: begin
                w_div_start = 1'b0;
            end
            ST_OUT: begin
                w_out_load = !r_m_tvalid || i_m_tready;
            end
        endcase
    end

    // clearing sweep and pending recompute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_dirty    <= 1'b1;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (w_cfg_wr) begin
                r_dirty <= 1'b1;
            end else if (w_cfg_start) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // bin sizes from the divider
    always_ff @(posedge i_clk) begin
        if (w_cap_x) begin
            r_bx <= w_div_quo[SRC_DIM_W-1:0];
            r_rx <= w_div_rem[DST_X_W-1:0];
        end
        if (w_cap_y) begin
            r_by <= w_div_quo[SRC_DIM_W-1:0];
            r_ry <= w_div_rem[DST_Y_W-1:0];
        end
    end

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col     <= '0;
            r_col_in_bin  <= '0;
            r_src_row     <= '0;
            r_row_in_band <= '0;
            r_bin_col     <= '0;
            r_band_row    <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_src_col    <= '0;
                r_bin_col    <= '0;
                r_col_in_bin <= '0;
                if (w_frame_row) begin
                    r_src_row     <= '0;
                    r_band_row    <= '0;
                    r_row_in_band <= '0;
                end else begin
                    r_src_row <= r_src_row + YW'(1);
                    if (w_band_end && !w_last_band) begin
                        r_band_row    <= r_band_row + YW'(1);
                        r_row_in_band <= '0;
                    end else begin
                        r_row_in_band <= r_row_in_band + YW'(1);
                    end
                end
            end else begin
                r_src_col <= r_src_col + XW'(1);
                if (w_bin_x_end && !w_last_bin_x) begin
                    r_bin_col    <= r_bin_col + BW'(1);
                    r_col_in_bin <= '0;
                end else begin
                    r_col_in_bin <= r_col_in_bin + XW'(1);
                end
            end
        end
    end

    // capture of the accepted word and its bin
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample     <= SAMPLE_BITS'(i_s_tdata[SAMPLE_W-1:0]);
            r_idx        <= r_bin_col;
            r_emit       <= w_emit;
            r_last_bin_x <= w_last_bin_x;
            r_last_band  <= w_last_band;
            r_out_x      <= OUT_X_W'(r_bin_col);
            r_out_y      <= OUT_Y_W'(r_band_row);
            r_frame_done <= w_row_end & w_frame_row;
        end
        if (r_state == ST_ACC) begin
            r_sum   <= w_sum;
            r_count <= w_prod;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_avg  <= w_avg[SAMPLE_W-1:0];
            r_m_x    <= r_out_x;
            r_m_y    <= r_out_y;
            r_m_last <= r_frame_done;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OUT_TDATA_W'({r_m_y, r_m_x, r_m_avg});
    assign o_m_tlast  = r_m_last;

endmodule

[rtl/gbad_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// uses gbad_pkg only for parameter defaults

module gbad_ram #(
    parameter int WIDTH = gbad_pkg::SUM_W,
    parameter int DEPTH = gbad_pkg::DEF_MAX_DST_WIDTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gbad_div.sv]
// unsigned restoring divider, one quotient bit per cycle
// depends on gbad_pkg for the status struct

module gbad_div #(
    parameter int NW = gbad_pkg::SUM_W,
    parameter int DW = gbad_pkg::CNT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NW-1:0]        i_dividend,
    input  logic [DW-1:0]        i_divisor,
    output gbad_pkg::t_div_stat  o_stat,
    output logic [NW-1:0]        o_quo,
    output logic [DW-1:0]        o_rem
);
    import gbad_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // trial subtraction of the next bit
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // shift and subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

[rtl/gbad_cfg.sv]
// configuration registers and clamping of the grid sizes
// depends on gbad_pkg for widths, reset values, indexes and the geometry struct

module gbad_cfg #(
    parameter int MAX_SRC_WIDTH  = gbad_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = gbad_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_WIDTH  = gbad_pkg::DEF_MAX_DST_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbad_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [gbad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output gbad_pkg::t_geom                   o_geom,
    output logic                              o_wr
);
    import gbad_pkg::*;

    logic [SRC_DIM_W-1:0] r_src_width;
    logic [SRC_DIM_W-1:0] r_src_height;
    logic [DST_X_W-1:0]   r_dst_width;
    logic [DST_Y_W-1:0]   r_dst_height;
    logic [SRC_DIM_W-1:0] w_sw;
    logic [SRC_DIM_W-1:0] w_sh;
    logic [SRC_DIM_W-1:0] w_dw_max;

    assign o_cfg_ready = 1'b1;
    assign o_wr        = i_cfg_valid;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DST_X_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DST_Y_W-1:0];
            endcase
        end
    end

    // source sizes clamped to 1..max
    always_comb begin
        if (r_src_width == '0) begin
            w_sw = SRC_DIM_W'(1);
        end else if (32'(r_src_width) > 32'(MAX_SRC_WIDTH)) begin
            w_sw = SRC_DIM_W'(MAX_SRC_WIDTH);
        end else begin
            w_sw = r_src_width;
        end
        if (r_src_height == '0) begin
            w_sh = SRC_DIM_W'(1);
        end else if (32'(r_src_height) > 32'(MAX_SRC_HEIGHT)) begin
            w_sh = SRC_DIM_W'(MAX_SRC_HEIGHT);
        end else begin
            w_sh = r_src_height;
        end
    end

    // bin counts clamped to 1..source size, bin columns also to MAX_DST_WIDTH
    assign w_dw_max = (32'(w_sw) > 32'(MAX_DST_WIDTH)) ? SRC_DIM_W'(MAX_DST_WIDTH) : w_sw;

    always_comb begin
        o_geom.sw = w_sw;
        o_geom.sh = w_sh;
        if (r_dst_width == '0) begin
            o_geom.dw = DST_X_W'(1);
        end else if (SRC_DIM_W'(r_dst_width) > w_dw_max) begin
            o_geom.dw = w_dw_max[DST_X_W-1:0];
        end else begin
            o_geom.dw = r_dst_width;
        end
        if (r_dst_height == '0) begin
            o_geom.dh = DST_Y_W'(1);
        end else if (r_dst_height > w_sh) begin
            o_geom.dh = w_sh;
        end else begin
            o_geom.dh = r_dst_height;
        end
    end

endmodule

[verif/grid_block_average_decimator_tb.sv]
// self-checking testbench of the grid block average decimator: streams source grids
// through the block and compares every bin word with a predictor kept in the bench
// depends on gbad_pkg and grid_block_average_decimator

module grid_block_average_decimator_tb;

    import gbad_pkg::*;

    localparam int MAX_SW    = DEF_MAX_SRC_WIDTH;
    localparam int MAX_SH    = DEF_MAX_SRC_HEIGHT;
    localparam int MAX_DW    = DEF_MAX_DST_WIDTH;
    localparam int SAMPLE_MAX = (1 << DEF_SAMPLE_BITS) - 1;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int WIDE_ITEMS    = 256;
    localparam int PRINT_LIMIT   = 30;

    typedef struct {
        logic [SAMPLE_W-1:0] average;
        logic [OUT_X_W-1:0]  out_x;
        logic [OUT_Y_W-1:0]  out_y;
        logic                frame_done;
    } t_bin_result;

    typedef enum int {FEED_CORNER, FEED_MAX, FEED_RANDOM} t_feed_kind;

    // dut ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // source words waiting to go out, bins waiting to come back
    logic [SAMPLE_W-1:0] pending_samples[$];
    t_bin_result         expected_bins[$];
    int unsigned         mismatch_count = 0;

    // predictor copy of the registers
    logic [SRC_DIM_W-1:0] grid_src_w = RST_SRC_WIDTH;
    logic [SRC_DIM_W-1:0] grid_src_h = RST_SRC_HEIGHT;
    logic [DST_X_W-1:0]   grid_dst_w = RST_DST_WIDTH;
    logic [DST_Y_W-1:0]   grid_dst_h = RST_DST_HEIGHT;

    // predictor copy of the row of bin sums and the raster position
    logic [SUM_W-1:0] bin_acc [MAX_DW];
    int unsigned pos_col = 0, pos_row = 0, pos_bin = 0;
    int unsigned pos_in_bin = 0, pos_band = 0, pos_in_band = 0;

    // sender burst and gap counters, receiver stall pattern
    int unsigned burst_left = 0, gap_left = 0;
    logic [15:0] rcv_tick = '0;
    logic [1:0]  rcv_mode = '0;

    logic [SAMPLE_W-1:0] corner_vals [8] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                                             16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};

    grid_block_average_decimator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SAMPLE_W'(SAMPLE_MAX);
            2: return SAMPLE_W'(SAMPLE_MAX - $urandom_range(0, 15));
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // add one source word into its bin and queue the bin word it closes, if any
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned sw, sh, dwmax, dw, dh, bx, rx, by, ry, idx;
        bit last_bin_x, last_band, row_end, frame_row, bin_x_end, band_end;
        longint unsigned cnt, quot;
        t_bin_result r;

        sw    = clamp_dim(grid_src_w, 1, MAX_SW);
        sh    = clamp_dim(grid_src_h, 1, MAX_SH);
        dwmax = (sw < MAX_DW) ? sw : MAX_DW;
        dw    = clamp_dim(grid_dst_w, 1, dwmax);
        dh    = clamp_dim(grid_dst_h, 1, sh);
        bx = sw / dw;
        rx = sw % dw;
        by = sh / dh;
        ry = sh % dh;

        // end tests compare with >= so that a resize mid-frame still wraps
        last_bin_x = pos_bin + 1 >= dw;
        last_band  = pos_band + 1 >= dh;
        row_end    = pos_col + 1 >= sw;
        frame_row  = pos_row + 1 >= sh;
        bin_x_end  = last_bin_x ? row_end : (pos_in_bin + 1 >= bx);
        band_end   = last_band ? frame_row : (pos_in_band + 1 >= by);
        idx = (pos_bin < MAX_DW) ? pos_bin : MAX_DW - 1;

        bin_acc[idx] = bin_acc[idx] + SUM_W'(s);

        if (bin_x_end && band_end) begin
            // last bin column and last band also carry the remainder
            cnt = (last_bin_x ? longint'(bx + rx) : longint'(bx)) *
                  (last_band ? longint'(by + ry) : longint'(by));
            quot = longint'(bin_acc[idx]) / cnt;
            if (quot > SAMPLE_MAX) quot = SAMPLE_MAX;
            r.average    = quot[SAMPLE_W-1:0];
            r.out_x      = pos_bin[OUT_X_W-1:0];
            r.out_y      = pos_band[OUT_Y_W-1:0];
            r.frame_done = row_end && frame_row;
            expected_bins.push_back(r);
            bin_acc[idx] = '0;
        end

        // advance the raster position
        if (row_end) begin
            pos_col    = 0;
            pos_bin    = 0;
            pos_in_bin = 0;
            if (frame_row) begin
                pos_row     = 0;
                pos_band    = 0;
                pos_in_band = 0;
            end else begin
                pos_row++;
                if (band_end && !last_band) begin
                    pos_band++;
                    pos_in_band = 0;
                end else begin
                    pos_in_band++;
                end
            end
        end else begin
            pos_col++;
            if (bin_x_end && !last_bin_x) begin
                pos_bin++;
                pos_in_bin = 0;
            end else begin
                pos_in_bin++;
            end
        end
    endtask

    // source driver: bursts of words with random gaps, word held until taken
    always @(posedge i_clk) begin : src_driver
        bit fire;
        fire = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (fire) void'(pending_samples.pop_front());
            if (i_s_tvalid && !fire) begin
                // hold the word on offer
            end else if (gap_left != 0) begin
                i_s_tvalid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_samples.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_samples[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern picked anew whenever rcv_tick[5:0] wraps to zero
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            rcv_tick <= rcv_tick + 1'b1;
            if (rcv_tick[5:0] == '0) rcv_mode <= 2'($urandom_range(0, 3));
            case (rcv_mode)
                2'd0: i_m_tready <= 1'b1;
                2'd1: i_m_tready <= rcv_tick[0];
                2'd2: i_m_tready <= ($urandom_range(0, 9) < 7);
                default: i_m_tready <= (rcv_tick[3:0] >= 4'd10);
            endcase
        end
    end

    // monitor: check bin words leaving, predict from source words taken
    always @(posedge i_clk) begin : monitor
        t_bin_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("bin word with nothing expected", o_m_tdata, 0);
                end else begin
                    want = expected_bins.pop_front();
                    if (o_m_tdata[15:0] !== want.average)
                        report_mismatch("average", o_m_tdata[15:0], want.average);
                    if (o_m_tdata[25:16] !== want.out_x)
                        report_mismatch("out_x", o_m_tdata[25:16], want.out_x);
                    if (o_m_tdata[37:26] !== want.out_y)
                        report_mismatch("out_y", o_m_tdata[37:26], want.out_y);
                    if (o_m_tlast !== want.frame_done)
                        report_mismatch("frame_done", o_m_tlast, want.frame_done);
                    if (o_m_tdata[39:38] !== 2'b00)
                        report_mismatch("tdata padding", o_m_tdata[39:38], 0);
                end
            end
            if (i_s_tvalid && o_s_tready) accumulate_sample(i_s_tdata[SAMPLE_W-1:0]);
        end
    end

    // one register write through the cfg channel
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  grid_src_w = val;
            CFG_SRC_HEIGHT: grid_src_h = val;
            CFG_DST_WIDTH:  grid_dst_w = val[DST_X_W-1:0];
            CFG_DST_HEIGHT: grid_dst_h = val[DST_Y_W-1:0];
        endcase
    endtask

    task automatic set_grid(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
        write_reg(CFG_DST_WIDTH, CFG_DATA_W'(dw));
        write_reg(CFG_DST_HEIGHT, CFG_DATA_W'(dh));
    endtask

    task automatic feed(int unsigned n, t_feed_kind kind);
        @(negedge i_clk);
        for (int unsigned k = 0; k < n; k++) begin
            case (kind)
                FEED_CORNER: pending_samples.push_back(corner_vals[k % 8]);
                FEED_MAX:    pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
                default:     pending_samples.push_back(random_sample());
            endcase
        end
    endtask

    // wait for the sender to empty and every bin word to return, then settle
    task automatic drain_block();
        int k;
        while (pending_samples.size() != 0 || i_s_tvalid) @(posedge i_clk);
        k = 0;
        while (expected_bins.size() != 0 && k < DRAIN_LIMIT) begin
            @(posedge i_clk);
            k++;
        end
        if (expected_bins.size() != 0) begin
            report_mismatch("bin words never arrived", 0, expected_bins.size());
            expected_bins.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random grid: mostly whole frames, sometimes cut short for a resize mid-frame
    task automatic random_phase(output int unsigned n);
        int unsigned sw, sh, dw, dh, frame_len;
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 8);
        dw = $urandom_range(1, sw);
        dh = $urandom_range(1, sh);
        case ($urandom_range(0, 9))
            0: begin
                dw = $urandom_range(0, 1) ? 0 : sw + $urandom_range(1, 30);
                dh = $urandom_range(0, 1) ? 0 : sh + $urandom_range(1, 30);
            end
            1: begin
                sw = $urandom_range(13, 40);
                sh = $urandom_range(1, 3);
                dw = $urandom_range(1, sw);
                dh = $urandom_range(1, sh);
            end
            2: begin
                sw = 0;
                dw = $urandom_range(0, 2);
            end
            default: ;
        endcase
        frame_len = clamp_dim(sw, 1, MAX_SW) * clamp_dim(sh, 1, MAX_SH);
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, frame_len);
        else n = frame_len * $urandom_range(1, 3);
        set_grid(sw, sh, dw, dh);
        feed(n, FEED_RANDOM);
        drain_block();
    endtask

    initial begin : stimulus
        int unsigned random_total, n;
        foreach (bin_acc[k]) bin_acc[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small grid with remainders on both axes, corner sample values
        set_grid(5, 3, 2, 2);
        feed(15, FEED_CORNER);
        drain_block();

        // zero sizes clamp to one: every word is a whole frame
        set_grid(0, 0, 0, 0);
        feed(4, FEED_CORNER);
        drain_block();

        // oversize registers clamp to the source and to the maxima
        set_grid(3, 8191, 2047, 8191);
        feed(3, FEED_RANDOM);
        drain_block();

        // partial bin of full-scale words, then shrink the row under it:
        // the leftover sum lands in a one-sample bin and saturates
        set_grid(6, 1, 1, 1);
        feed(3, FEED_MAX);
        drain_block();
        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(1));
        feed(1, FEED_MAX);
        drain_block();

        // widest row with the most bin columns, first part of the row only
        set_grid(MAX_SW, 1, MAX_DW, 1);
        feed(WIDE_ITEMS, FEED_RANDOM);
        drain_block();

        // tallest grid with one-row bands
        set_grid(1, MAX_SH, 1, MAX_SH);
        feed(40, FEED_RANDOM);
        drain_block();

        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            random_phase(n);
            random_total += n;
        end

        if (mismatch_count == 0) begin
            $display("grid_block_average_decimator_tb OK");
        end else begin
            $display("grid_block_average_decimator_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("grid_block_average_decimator_tb NOT OK");
        $finish;
    end

endmodule
